[hdl/ps2mt_pkg.sv]
package ps2mt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_BITS       = 12;
  localparam int CFG_BITS       = 13;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

  localparam int POS_X_RESET = 5;
  localparam int POS_Y_RESET = 2;

  // status byte bit positions
  localparam int ST_LEFT   = 0;
  localparam int ST_RIGHT  = 1;
  localparam int ST_MIDDLE = 2;
  localparam int ST_MARKER = 3;
  localparam int ST_X_SIGN = 4;
  localparam int ST_Y_SIGN = 5;
  localparam int ST_X_OVF  = 6;
  localparam int ST_Y_OVF  = 7;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic                left;
    logic                right;
    logic                middle;
    logic                x_ovf;
    logic                y_ovf;
    logic                marker;
  } result_t;

endpackage

[hdl/ps2_mouse_packet_tracker.sv]
// Groups PS/2 mouse bytes into three-byte packets (status, X delta, Y delta)
// and tracks a cursor clamped to screen_width-1 and screen_height-1, Y
// growing downward. One byte is taken per cycle when not stalled; the third
// byte of a packet updates the position in the same cycle and loads the output
// register, so its result is offered on the next cycle. The first two bytes
// give no result. The byte channel stalls only while the output register
// holds a result that is itself stalled. Configuration writes are always ready.
module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          data_byte,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [ps2mt_pkg::OUT_BITS-1:0]      cursor_x,
  output logic [ps2mt_pkg::OUT_BITS-1:0]      cursor_y,
  output logic                                left_pressed,
  output logic                                right_pressed,
  output logic                                middle_pressed,
  output logic                                x_overflowed,
  output logic                                y_overflowed,
  output logic                                marker_bit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ps2mt_pkg::CFG_BITS-1:0]      cfg_data
);
  import ps2mt_pkg::*;

  logic [CFG_BITS-1:0] screen_width;
  logic [CFG_BITS-1:0] screen_height;
  logic                byte_accept;
  logic                pkt_valid;
  packet_t             pkt;
  result_t             result;

  assign cfg_ready   = 1'b1;
  assign byte_stall  = result_valid && result_stall;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ps2mt_packet_asm u_asm (
    .clk       (clk),
    .rst       (rst),
    .accept    (byte_accept),
    .data_byte (data_byte),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  ps2mt_cursor_upd #(
    .CB (COORD_BITS)
  ) u_upd (
    .clk           (clk),
    .rst           (rst),
    .pkt_valid     (pkt_valid),
    .pkt           (pkt),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .result        (result)
  );

  assign cursor_x       = result.x;
  assign cursor_y       = result.y;
  assign left_pressed   = result.left;
  assign right_pressed  = result.right;
  assign middle_pressed = result.middle;
  assign x_overflowed   = result.x_ovf;
  assign y_overflowed   = result.y_ovf;
  assign marker_bit     = result.marker;

`ifndef ASSERT_OFF
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> byte_stall)
    else $error("byte accepted while a stalled result is pending");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_valid && !byte_stall))
    else $error("result appeared without an accepted byte");
`endif

endmodule

[hdl/ps2mt_packet_asm.sv]
module ps2mt_packet_asm (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output logic               pkt_valid,
  output ps2mt_pkg::packet_t pkt
);
  import ps2mt_pkg::*;

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_DX     = 2'd1;
  localparam logic [1:0] PH_DY     = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held_status;
  logic [7:0] held_dx;

  always_comb begin
    case (phase)
      PH_DX:   phase_next = PH_DY;
      PH_DY:   phase_next = PH_STATUS;
      default: phase_next = PH_DX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STATUS;
      held_status <= '0;
      held_dx     <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_DX) begin
        held_dx <= data_byte;
      end else if (phase != PH_DY) begin
        held_status <= data_byte;
      end
    end
  end

  assign pkt_valid  = accept && (phase == PH_DY);
  assign pkt.status = held_status;
  assign pkt.dx     = held_dx;
  assign pkt.dy     = data_byte;

endmodule

[hdl/ps2mt_cursor_upd.sv]
module ps2mt_cursor_upd #(
  parameter int CB = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pkt_valid,
  input  ps2mt_pkg::packet_t                pkt,
  input  logic [ps2mt_pkg::CFG_BITS-1:0]    screen_width,
  input  logic [ps2mt_pkg::CFG_BITS-1:0]    screen_height,
  input  logic                              result_stall,
  output logic                              result_valid,
  output ps2mt_pkg::result_t                result
);
  import ps2mt_pkg::*;

  localparam int LW = (CB + 1 > CFG_BITS) ? CB + 1 : CFG_BITS;
  localparam int SW = CB + 2;
  localparam int EW = CB + OUT_BITS;

  function automatic logic [CB-1:0] upper_limit(input logic [CFG_BITS-1:0] size);
    logic [LW-1:0] s;
    logic [LW-1:0] cap;
    s   = LW'(size);
    cap = LW'(1) << CB;
    if (s == '0) begin
      upper_limit = '0;
    end else if (s > cap) begin
      upper_limit = CB'(cap - LW'(1));
    end else begin
      upper_limit = CB'(s - LW'(1));
    end
  endfunction

  function automatic logic [CB-1:0] clamp_move(input logic [CB-1:0] pos,
                                               input logic signed [9:0] delta,
                                               input logic [CB-1:0] hi);
    logic signed [SW-1:0] v;
    v = $signed({2'b00, pos}) + SW'(delta);
    if (v < 0) begin
      clamp_move = '0;
    end else if (v > $signed({2'b00, hi})) begin
      clamp_move = hi;
    end else begin
      clamp_move = CB'(v);
    end
  endfunction

  logic [CB-1:0]       pos_x;
  logic [CB-1:0]       pos_y;
  logic [CB-1:0]       pos_x_next;
  logic [CB-1:0]       pos_y_next;
  logic signed [9:0]   dx;
  logic signed [9:0]   neg_dy;
  logic [EW-1:0]       x_ext;
  logic [EW-1:0]       y_ext;

  assign dx     = $signed({{2{pkt.status[ST_X_SIGN]}}, pkt.dx});
  assign neg_dy = -$signed({{2{pkt.status[ST_Y_SIGN]}}, pkt.dy});

  assign pos_x_next = clamp_move(pos_x, dx, upper_limit(screen_width));
  assign pos_y_next = clamp_move(pos_y, neg_dy, upper_limit(screen_height));

  assign x_ext = EW'(pos_x_next);
  assign y_ext = EW'(pos_y_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= CB'(POS_X_RESET);
      pos_y        <= CB'(POS_Y_RESET);
      result_valid <= 1'b0;
    end else if (pkt_valid) begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid) begin
      result.x      <= x_ext[OUT_BITS-1:0];
      result.y      <= y_ext[OUT_BITS-1:0];
      result.left   <= pkt.status[ST_LEFT];
      result.right  <= pkt.status[ST_RIGHT];
      result.middle <= pkt.status[ST_MIDDLE];
      result.x_ovf  <= pkt.status[ST_X_OVF];
      result.y_ovf  <= pkt.status[ST_Y_OVF];
      result.marker <= pkt.status[ST_MARKER];
    end
  end

endmodule
